// ===== design/sha_pkg.sv =====
// shared types, round constants and sigma functions for the sha-256 stream hasher
package sha_pkg;

    localparam int WORD_W    = 32;
    localparam int RAM_DEPTH = 16;
    localparam int RAM_AW    = 4;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    // control from the sequencer to the round datapath
    typedef struct packed {
        logic       load;
        logic       round;
        logic       finalize;
        logic       reinit;
        logic [5:0] round_idx;
        logic [2:0] out_idx;
    } core_ctrl_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== design/sha_block_ram.sv =====
// 16 x 32 block buffer memory, one write port, one registered read port
module sha_block_ram (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [sha_pkg::RAM_AW-1:0] wr_addr,
    input  logic [sha_pkg::WORD_W-1:0] wr_data,
    input  logic [sha_pkg::RAM_AW-1:0] rd_addr,
    output logic [sha_pkg::WORD_W-1:0] rd_data
);
    import sha_pkg::*;

    logic [WORD_W-1:0] mem [RAM_DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/sha_core.sv =====
// round datapath: hash state, working variables and message schedule window
module sha_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sha_pkg::core_ctrl_t        ctrl,
    input  logic [sha_pkg::WORD_W-1:0] block_word,
    output logic [sha_pkg::WORD_W-1:0] digest_word
);
    import sha_pkg::*;

    logic [7:0][31:0]  hash_reg, hash_next;
    logic [7:0][31:0]  work_reg, work_next;
    logic [15:0][31:0] sched_reg, sched_next;

    logic [31:0] w, t1, t2, ch, maj;
    logic [31:0] a, b, c, e, f, g, h;

    // message word: from the buffer for the first 16 rounds, else expanded
    always_comb
    begin
        if (ctrl.round_idx[5:4] == 2'd0)
        begin
            w = block_word;
        end
        else
        begin
            w = small_sigma1(sched_reg[14]) + sched_reg[9]
              + small_sigma0(sched_reg[1]) + sched_reg[0];
        end
    end

    // one compression round
    always_comb
    begin
        a   = work_reg[0];
        b   = work_reg[1];
        c   = work_reg[2];
        e   = work_reg[4];
        f   = work_reg[5];
        g   = work_reg[6];
        h   = work_reg[7];
        ch  = (e & f) ^ (~e & g);
        maj = (a & b) ^ (a & c) ^ (b & c);
        t1  = h + big_sigma1(e) + ch + ROUND_K[ctrl.round_idx] + w;
        t2  = big_sigma0(a) + maj;
    end

    // next values of the state registers
    always_comb
    begin
        hash_next  = hash_reg;
        work_next  = work_reg;
        sched_next = sched_reg;
        if (ctrl.load)
        begin
            work_next = hash_reg;
        end
        if (ctrl.round)
        begin
            work_next[7] = g;
            work_next[6] = f;
            work_next[5] = e;
            work_next[4] = work_reg[3] + t1;
            work_next[3] = c;
            work_next[2] = b;
            work_next[1] = a;
            work_next[0] = t1 + t2;
            for (int k = 0; k < 15; k++)
            begin
                sched_next[k] = sched_reg[k+1];
            end
            sched_next[15] = w;
        end
        if (ctrl.finalize)
        begin
            for (int k = 0; k < 8; k++)
            begin
                hash_next[k] = hash_reg[k] + work_reg[k];
            end
        end
        if (ctrl.reinit)
        begin
            for (int k = 0; k < 8; k++)
            begin
                hash_next[k] = INIT_HASH[k];
            end
        end
    end

    // hash state starts from the initial values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 8; k++)
            begin
                hash_reg[k] <= INIT_HASH[k];
            end
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    // working variables and schedule window
    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        sched_reg <= sched_next;
    end

    assign digest_word = hash_reg[ctrl.out_idx];

    // a load always precedes round zero
    a_load_before_round0 : assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.round && ctrl.round_idx == 6'd0) |-> $past(ctrl.load))
        else $error("round zero without load");

    // finalize follows the last round
    a_final_after_round63 : assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.round && ctrl.round_idx == 6'd63) |=> ctrl.finalize)
        else $error("no finalize after last round");

    // load and round never overlap
    a_load_round_excl : assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.load && ctrl.round))
        else $error("load during round");

endmodule

// ===== design/sha256_stream_hasher.sv =====
// sha-256 stream hasher top level: byte intake, padding sequencer and digest output
//
// item channel (item_valid/item_ready): one beat is one command. kind 0 appends
// data_byte to the message, kind 1 closes the message and requests the digest.
// result channel (result_valid/result_ready): eight beats per digest, word 0
// first, word_index counting up, last high on word 7.
// data bytes are taken back to back while idle; every 64th byte starts a
// compression: a load step, 64 rounds at one round per cycle and an add-back
// step.
// a finish beat writes the padding words, from the current word position up to
// word 15, compresses, repeats both for a second block when 56 or more bytes are
// buffered, then presents the digest.
// item_ready is low while a block compresses or the digest is presented.
// a stalled receiver holds the current digest word; the block waits.
// after word 7 is taken the hash state and byte count go back to their
// initial values. reset does the same and needs no clearing pass.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last
);
    import sha_pkg::*;

    state_t      state_reg, state_next;
    logic [63:0] count_reg, count_next;
    logic [23:0] acc_reg, acc_next;
    logic [3:0]  pad_idx_reg, pad_idx_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        finish_reg, finish_next;
    logic        extra_reg, extra_next;
    logic        first_reg, first_next;

    logic [5:0]        pos;
    logic [63:0]       bit_len;
    logic              item_beat, result_beat;
    logic [31:0]       merged_word;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]       ram_wdata, ram_rdata;
    core_ctrl_t        ctrl;

    assign pos         = count_reg[5:0];
    assign bit_len     = {count_reg[60:0], 3'b000};
    assign item_beat   = item_valid && item_ready;
    assign result_beat = result_valid && result_ready;

    // partial word closed with the pad byte
    always_comb
    begin
        case (pos[1:0])
            2'd0:    merged_word = {PAD_BYTE, 24'h0};
            2'd1:    merged_word = {acc_reg[7:0], PAD_BYTE, 16'h0};
            2'd2:    merged_word = {acc_reg[15:0], PAD_BYTE, 8'h0};
            2'd3:    merged_word = {acc_reg[23:0], PAD_BYTE};
            default: merged_word = {PAD_BYTE, 24'h0};
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (kind)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (pos == 6'd63)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_idx_reg == 4'd15)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (extra_reg)
                begin
                    state_next = ST_PAD;
                end
                else if (finish_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (result_ready && out_idx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        item_ready     = 1'b0;
        result_valid   = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = pos[5:2];
        ram_wdata      = {acc_reg, data_byte};
        ram_raddr      = '0;
        ctrl           = '0;
        ctrl.round_idx = round_reg;
        ctrl.out_idx   = out_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                ram_we     = item_valid && !kind && (pos[1:0] == 2'd3);
            end
            ST_PAD:
            begin
                ram_we    = 1'b1;
                ram_waddr = pad_idx_reg;
                if (first_reg && pad_idx_reg == pos[5:2])
                begin
                    ram_wdata = merged_word;
                end
                else if (!extra_reg && pad_idx_reg == 4'd14)
                begin
                    ram_wdata = bit_len[63:32];
                end
                else if (!extra_reg && pad_idx_reg == 4'd15)
                begin
                    ram_wdata = bit_len[31:0];
                end
                else
                begin
                    ram_wdata = '0;
                end
            end
            ST_LOAD:
            begin
                ctrl.load = 1'b1;
            end
            ST_ROUND:
            begin
                ctrl.round = 1'b1;
                ram_raddr  = round_reg[3:0] + 4'd1;
            end
            ST_FINAL:
            begin
                ctrl.finalize = 1'b1;
            end
            ST_OUT:
            begin
                result_valid = 1'b1;
                ctrl.reinit  = result_ready && (out_idx_reg == 3'd7);
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // counters and flags
    always_comb
    begin
        count_next   = count_reg;
        acc_next     = acc_reg;
        pad_idx_next = pad_idx_reg;
        round_next   = round_reg;
        out_idx_next = out_idx_reg;
        finish_next  = finish_reg;
        extra_next   = extra_reg;
        first_next   = first_reg;
        if (item_beat && !kind)
        begin
            acc_next   = {acc_reg[15:0], data_byte};
            count_next = count_reg + 64'd1;
        end
        if (item_beat && kind)
        begin
            finish_next  = 1'b1;
            extra_next   = (pos[5:3] == 3'd7);
            first_next   = 1'b1;
            pad_idx_next = pos[5:2];
        end
        if (state_reg == ST_PAD)
        begin
            pad_idx_next = pad_idx_reg + 4'd1;
        end
        if (state_reg == ST_LOAD)
        begin
            round_next = '0;
        end
        if (state_reg == ST_ROUND)
        begin
            round_next = round_reg + 6'd1;
        end
        if (state_reg == ST_FINAL)
        begin
            if (extra_reg)
            begin
                extra_next   = 1'b0;
                first_next   = 1'b0;
                pad_idx_next = '0;
            end
            out_idx_next = '0;
        end
        if (result_beat)
        begin
            out_idx_next = out_idx_reg + 3'd1;
            if (out_idx_reg == 3'd7)
            begin
                count_next  = '0;
                finish_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pad_idx_reg <= '0;
            round_reg   <= '0;
            out_idx_reg <= '0;
            finish_reg  <= 1'b0;
            extra_reg   <= 1'b0;
            first_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pad_idx_reg <= pad_idx_next;
            round_reg   <= round_next;
            out_idx_reg <= out_idx_next;
            finish_reg  <= finish_next;
            extra_reg   <= extra_next;
            first_reg   <= first_next;
        end
    end

    // partial word bytes, payload only
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    sha_block_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    sha_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .block_word  (ram_rdata),
        .digest_word (digest_word)
    );

    assign word_index = out_idx_reg;
    assign last       = (out_idx_reg == 3'd7);

    // the 64th byte of a block starts a compression
    a_full_block_loads : assert property (@(posedge clk) disable iff (!rst_n)
        (item_beat && !kind && pos == 6'd63) |=> (state_reg == ST_LOAD))
        else $error("full block not compressed");

    // the final padding word leads straight into a compression
    a_pad_end_loads : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD && pad_idx_reg == 4'd15) |=> (state_reg == ST_LOAD))
        else $error("padding did not end in a load");

    // last digest beat restarts the message
    a_last_clears_count : assert property (@(posedge clk) disable iff (!rst_n)
        (result_beat && last) |=> (count_reg == 64'd0 && state_reg == ST_IDLE))
        else $error("message state not reset after digest");

    // no new item is taken while the digest is presented
    a_no_item_during_out : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !item_ready)
        else $error("item accepted while digest pending");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the sha-256 stream hasher with its digest predictor
package sha_tb_pkg;

    // item kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam int         DIGEST_WORDS = 8;

    localparam bit [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // one expected digest beat
    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } digest_beat_t;

    class digest_scoreboard;
        bit [31:0]    hash_st [8];
        bit [63:0]    msg_bytes;
        bit [7:0]     blk [64];
        digest_beat_t digest_queue [$];
        int unsigned  fail_count;

        function new();
            fail_count = 0;
            foreach (blk[i])
            begin
                blk[i] = 8'h00;
            end
            restart_message();
        endfunction

        function void restart_message();
            foreach (hash_st[i])
            begin
                hash_st[i] = SHA_IV[i];
            end
            msg_bytes = '0;
        endfunction

        function bit [31:0] rot_right(bit [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // one 64-round compression of the buffered block into the hash state
        function void compress_blk();
            bit [31:0] sched [64];
            bit [31:0] v [8];
            bit [31:0] s0, s1, t1, t2;
            for (int i = 0; i < 16; i++)
            begin
                sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            end
            for (int i = 16; i < 64; i++)
            begin
                s0 = rot_right(sched[i-15], 7) ^ rot_right(sched[i-15], 18)
                     ^ (sched[i-15] >> 3);
                s1 = rot_right(sched[i-2], 17) ^ rot_right(sched[i-2], 19)
                     ^ (sched[i-2] >> 10);
                sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
            end
            v = hash_st;
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + sched[i];
                t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++)
            begin
                hash_st[j] = hash_st[j] + v[j];
            end
        endfunction

        // update the predicted state for one accepted item beat
        function void note_item(logic k, logic [7:0] b);
            int unsigned  pos;
            bit [63:0]    bit_len;
            digest_beat_t beat;
            pos = 32'(msg_bytes[5:0]);
            if (k == KIND_DATA)
            begin
                blk[pos] = b;
                msg_bytes = msg_bytes + 64'd1;
                if (pos == 63)
                begin
                    compress_blk();
                end
                return;
            end
            // pad mark, then an extra block when the length field no longer fits
            blk[pos] = PAD_MARK;
            pos = pos + 1;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    blk[pos] = 8'h00;
                    pos = pos + 1;
                end
                compress_blk();
                pos = 0;
            end
            while (pos < 56)
            begin
                blk[pos] = 8'h00;
                pos = pos + 1;
            end
            bit_len = msg_bytes << 3;
            for (int i = 0; i < 8; i++)
            begin
                blk[56+i] = bit_len[63-8*i -: 8];
            end
            compress_blk();
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                beat.word = hash_st[i];
                beat.idx  = 3'(i);
                beat.fin  = (i == DIGEST_WORDS - 1);
                digest_queue.push_back(beat);
            end
            restart_message();
        endfunction

        // compare one accepted digest beat with the oldest expectation
        function void check_word(logic [31:0] w, logic [2:0] idx, logic lst);
            digest_beat_t exp_beat;
            if (digest_queue.size() == 0)
            begin
                $error("digest beat with nothing expected: digest_word %h", w);
                fail_count++;
                return;
            end
            exp_beat = digest_queue.pop_front();
            if (w !== exp_beat.word)
            begin
                $error("digest_word expected %h actual %h", exp_beat.word, w);
                fail_count++;
            end
            if (idx !== exp_beat.idx)
            begin
                $error("word_index expected %0d actual %0d", exp_beat.idx, idx);
                fail_count++;
            end
            if (lst !== exp_beat.fin)
            begin
                $error("last expected %b actual %b", exp_beat.fin, lst);
                fail_count++;
            end
        endfunction
    endclass

endpackage

module tb;
    import sha_tb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic        result_valid;
    logic        result_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    digest_scoreboard sb;
    int unsigned      items_sent;
    int unsigned      finishes_sent;
    int unsigned      send_calm;
    int unsigned      recv_calm;

    sha256_stream_hasher u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last         (last)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // random gap with occasional stretches of back-to-back beats
    function automatic int unsigned draw_gap(ref int unsigned calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // drive one item beat and wait for its acceptance
    task automatic send_item(input logic k, input logic [7:0] b);
        int unsigned gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= k;
        data_byte  <= b;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        sb.note_item(k, b);
        items_sent++;
        if (k == KIND_FINISH)
        begin
            finishes_sent++;
        end
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned n = 0; n < len; n++)
        begin
            send_item(KIND_DATA, pick_byte());
        end
        send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // result side: random stalls, every accepted beat checked
    initial
    begin
        int unsigned gap;
        result_ready <= 1'b0;
        recv_calm = 0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(recv_calm);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
            begin
                @(posedge clk);
            end
            sb.check_word(digest_word, word_index, last);
        end
    end

    // stimulus and end of run
    initial
    begin
        int unsigned len;
        sb = new();
        items_sent    = 0;
        finishes_sent = 0;
        send_calm     = 0;
        rst_n         = 1'b0;
        item_valid   <= 1'b0;
        kind         <= KIND_DATA;
        data_byte    <= 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty messages, back to back, with the ignored byte at both extremes
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_FINISH, 8'hff);
        // short messages with extreme and pad-like bytes
        send_item(KIND_DATA, 8'h61);
        send_item(KIND_DATA, 8'h62);
        send_item(KIND_DATA, 8'h63);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_DATA, 8'hff);
        send_item(KIND_FINISH, 8'hff);
        send_item(KIND_DATA, 8'h80);
        send_item(KIND_DATA, 8'h7f);
        send_item(KIND_FINISH, 8'h55);

        // padding corners: length just fits, extra block needed, exact block
        send_message(55);
        send_message(56);
        send_message(64);

        // random messages, mostly short
        while (items_sent < 270 || finishes_sent < 10)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(0, 8);
                4:          len = $urandom_range(57, 63);
                5:          len = $urandom_range(119, 129);
                default:    len = $urandom_range(0, 40);
            endcase
            send_message(len);
        end
        item_valid <= 1'b0;

        // drain, then watch for stray beats
        while (sb.digest_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
        if (sb.fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
